[src/cawa_pkg.sv]
package cawa_pkg;

  // Field widths
  localparam int RAW_W      = 16;
  localparam int GAIN_W     = 26;
  localparam int OFF_W      = 45;
  localparam int PROD_W     = RAW_W + GAIN_W + 1;
  localparam int SUM_W      = 58;
  localparam int MEAN_W     = 32;
  localparam int CNT_OUT_W  = 13;
  localparam int N_AXIS     = 3;
  localparam int AXIS_W     = 2;

  // Q24 sums to Q16 means: drop eight fraction bits before dividing
  localparam int FRAC_SHIFT = 8;
  localparam int DVD_W      = SUM_W - FRAC_SHIFT;

  localparam int MAX_WINDOW_DEF = 4096;

  // Stream and configuration port widths
  localparam int IN_TDATA_W  = N_AXIS * RAW_W;
  localparam int OUT_FIELD_W = N_AXIS * MEAN_W + CNT_OUT_W + 2;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = OFF_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_Z  = 3'd5;

  // Operation codes carried in tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Saturation limits of a Q16 mean
  localparam logic [MEAN_W-1:0] MEAN_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [MEAN_W-1:0] MEAN_NEG_MAG = 32'h8000_0000;

  localparam logic [AXIS_W-1:0] AXIS_LAST = 2'd2;

  typedef logic [AXIS_W-1:0] axis_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV_GO,
    ST_DIV_RUN,
    ST_EMIT
  } seq_state_t;

  // Control word from the sequencer to the accumulator datapath
  typedef struct packed {
    logic  mul_en;
    logic  acc_en;
    logic  clr;
    axis_t axis;
  } acc_ctrl_t;

endpackage

[src/cawa_accum.sv]
module cawa_accum
  import cawa_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst_n,
  input  acc_ctrl_t                         ctrl,
  input  logic [N_AXIS-1:0][RAW_W-1:0]      raw,
  input  logic [N_AXIS-1:0][GAIN_W-1:0]     gain,
  input  logic [N_AXIS-1:0][OFF_W-1:0]      offset,
  output logic [N_AXIS-1:0][SUM_W-1:0]      sum
);

  logic signed [PROD_W-1:0] prod_r;
  logic [N_AXIS-1:0][SUM_W-1:0] sum_r;
  logic signed [RAW_W-1:0]  raw_sel;
  logic signed [GAIN_W:0]   gain_sel;
  logic [SUM_W-1:0]         prod_ext;
  logic [SUM_W-1:0]         off_ext;
  logic [SUM_W-1:0]         sum_nxt;

  // Select the axis operands for the shared multiplier
  assign raw_sel  = $signed(raw[ctrl.axis]);
  assign gain_sel = $signed({1'b0, gain[ctrl.axis]});

  // Register the product of one axis
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= raw_sel * gain_sel;
    end
  end

  // Sign-extend product and bias to the sum width, then accumulate
  assign prod_ext = {{(SUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign off_ext  = {{(SUM_W-OFF_W){offset[ctrl.axis][OFF_W-1]}}, offset[ctrl.axis]};
  assign sum_nxt  = sum_r[ctrl.axis] + prod_ext - off_ext;

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      sum_r <= '0;
    end else if (ctrl.acc_en) begin
      sum_r[ctrl.axis] <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

[src/cawa_div.sv]
module cawa_div
  import cawa_pkg::*;
#(
  parameter int DVD_BITS = DVD_W,
  parameter int DVS_BITS = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DVD_BITS-1:0] dividend,
  input  logic [DVS_BITS-1:0] divisor,
  output logic                busy,
  output logic                done,
  output logic [DVD_BITS-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_BITS);

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   step_r;
  logic [DVD_BITS-1:0] quo_r;
  logic [DVS_BITS-1:0] rem_r;
  logic [DVS_BITS:0]   rem_sh;
  logic [DVS_BITS:0]   rem_diff;
  logic                fits;
  logic [DVS_BITS-1:0] rem_nxt;
  logic [DVD_BITS-1:0] quo_nxt;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh   = {rem_r, quo_r[DVD_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign fits     = (rem_sh >= {1'b0, divisor});
  assign rem_nxt  = fits ? rem_diff[DVS_BITS-1:0] : rem_sh[DVS_BITS-1:0];
  assign quo_nxt  = {quo_r[DVD_BITS-2:0], fits};

  // Step counter and handshake flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DVD_BITS - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r - 1'b1;
      end
    end
  end

  // Dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[src/calibrated_axis_window_averager_unit.sv]
// Channel  | Dir | Fields
// in_      | in  | tuser: operation; tdata: raw_x, raw_y, raw_z
// out_     | out | tdata: mean_x, mean_y, mean_z, sample_count, window_empty,
//          |     |        window_overflow
// cfg_     | in  | we, index (0..5 = gain_x..z, offset_x..z), wdata
//
// A sample word is accepted, then multiplied and accumulated for each axis in
// turn on the one shared 16x27 multiplier and 58-bit adder.
// A window-end word runs the bit-serial divider once per axis; an empty
// window skips the divider and goes straight to the emit state. A full
// window drops a sample without accumulating it.
// A finished result sits in the output register; samples keep being accepted
// while it waits, and the next window end waits in the emit state.
// Reset is synchronous, active low, and clears sums, count, flags and configuration registers.
module calibrated_axis_window_averager_unit
  import cawa_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // raw_x, raw_y, raw_z
  input  logic                   in_tuser,   // operation
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // mean_x, mean_y, mean_z, sample_count, window_empty, window_overflow, pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  seq_state_t state_r, state_nxt;

  logic [N_AXIS-1:0][GAIN_W-1:0] gain_r;
  logic [N_AXIS-1:0][OFF_W-1:0]  off_r;
  logic [N_AXIS-1:0][RAW_W-1:0]  raw_r;
  logic [N_AXIS-1:0][SUM_W-1:0]  sum;
  logic [N_AXIS-1:0][MEAN_W-1:0] mean_stage_r;
  logic [N_AXIS-1:0][MEAN_W-1:0] out_mean_r;
  logic                          op_r;
  axis_t                         axis_r;
  logic [CNT_W-1:0]              cnt_r;
  logic                          dropped_r;
  logic                          neg_r;
  logic                          out_tvalid_r;
  logic [CNT_OUT_W-1:0]          out_cnt_r;
  logic                          out_empty_r;
  logic                          out_ovf_r;

  logic             in_acc;
  logic             full;
  logic             empty;
  acc_ctrl_t        acc_ctrl;
  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0] sum_mag;
  logic [MEAN_W-1:0] mean_sat;
  logic             emit_go;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_wide;

  assign in_acc = in_tvalid && in_tready;
  assign full   = (cnt_r == CNT_W'(MAX_WINDOW));
  assign empty  = (cnt_r == '0);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
      off_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_X: gain_r[0] <= cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_Y: gain_r[1] <= cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_Z: gain_r[2] <= cfg_wdata[GAIN_W-1:0];
        CFG_OFF_X:  off_r[0]  <= cfg_wdata;
        CFG_OFF_Y:  off_r[1]  <= cfg_wdata;
        CFG_OFF_Z:  off_r[2]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == OP_SAMPLE) begin
            state_nxt = full ? ST_IDLE : ST_MUL;
          end else begin
            state_nxt = empty ? ST_EMIT : ST_DIV_GO;
          end
        end
      end
      ST_MUL:     state_nxt = ST_ACC;
      ST_ACC:     state_nxt = (axis_r == AXIS_LAST) ? ST_IDLE : ST_MUL;
      ST_DIV_GO:  state_nxt = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (div_done) begin
          state_nxt = (axis_r == AXIS_LAST) ? ST_EMIT : ST_DIV_GO;
        end
      end
      ST_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready       = 1'b0;
    acc_ctrl.mul_en = 1'b0;
    acc_ctrl.acc_en = 1'b0;
    acc_ctrl.clr    = 1'b0;
    acc_ctrl.axis   = axis_r;
    div_start       = 1'b0;
    emit_go         = 1'b0;
    case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_MUL:    acc_ctrl.mul_en = 1'b1;
      ST_ACC:    acc_ctrl.acc_en = 1'b1;
      ST_DIV_GO: div_start = 1'b1;
      ST_EMIT: begin
        emit_go      = !out_tvalid_r || out_tready;
        acc_ctrl.clr = emit_go;
      end
      default: ;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      axis_r    <= '0;
      cnt_r     <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        axis_r <= '0;
        if (in_tuser == OP_SAMPLE && full) begin
          dropped_r <= 1'b1;
        end
      end
      // Advance the axis after each accumulate or division
      if ((state_r == ST_ACC) || (state_r == ST_DIV_RUN && div_done)) begin
        axis_r <= (axis_r == AXIS_LAST) ? '0 : axis_r + 1'b1;
      end
      if (state_r == ST_ACC && axis_r == AXIS_LAST) begin
        cnt_r <= cnt_r + 1'b1;
      end
      // Clear the window as its result leaves
      if (emit_go) begin
        cnt_r     <= '0;
        dropped_r <= 1'b0;
      end
    end
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_tuser;
      raw_r[0] <= in_tdata[RAW_W-1:0];
      raw_r[1] <= in_tdata[2*RAW_W-1:RAW_W];
      raw_r[2] <= in_tdata[3*RAW_W-1:2*RAW_W];
    end
  end

  cawa_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (acc_ctrl),
    .raw    (raw_r),
    .gain   (gain_r),
    .offset (off_r),
    .sum    (sum)
  );

  // Magnitude of the selected sum, Q24 to Q16 by dropping eight bits
  assign sum_sel = sum[axis_r];
  assign sum_mag = sum_sel[SUM_W-1] ? (~sum_sel + 1'b1) : sum_sel;

  cawa_div #(
    .DVD_BITS (DVD_W),
    .DVS_BITS (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag[SUM_W-1:FRAC_SHIFT]),
    .divisor  (cnt_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg_r <= sum_sel[SUM_W-1];
    end
  end

  // Saturate the quotient and restore the sign
  always_comb begin
    if (!neg_r) begin
      mean_sat = (div_quo > DVD_W'(MEAN_POS_MAX)) ? MEAN_POS_MAX : div_quo[MEAN_W-1:0];
    end else if (div_quo > DVD_W'(MEAN_NEG_MAG)) begin
      mean_sat = MEAN_NEG_MAG;
    end else begin
      mean_sat = ~div_quo[MEAN_W-1:0] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV_RUN && div_done) begin
      mean_stage_r[axis_r] <= mean_sat;
    end
  end

  // Output register
  assign cnt_wide = {{CNT_OUT_W{1'b0}}, cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit_go) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_mean_r  <= empty ? '0 : mean_stage_r;
      out_cnt_r   <= cnt_wide[CNT_OUT_W-1:0];
      out_empty_r <= empty;
      out_ovf_r   <= dropped_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}}, out_ovf_r, out_empty_r,
                       out_cnt_r, out_mean_r[2], out_mean_r[1], out_mean_r[0]};

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_WINDOW))
    else $error("window count above its limit");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_MUL || state_r == ST_ACC) |-> !div_busy)
    else $error("divider running outside a window end");

  a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == OP_SAMPLE && full) |=> (dropped_r && state_r == ST_IDLE))
    else $error("full window did not drop the sample");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_empty_r) |-> (out_mean_r == '0 && out_cnt_r == '0))
    else $error("empty window result not zero");

  a_op_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_GO || state_r == ST_EMIT) |-> (op_r == OP_TICK))
    else $error("division started without a window end");

endmodule
